FILE: rtl/core/tpld_pkg.sv
package tpld_pkg;

  // Coordinate geometry.
  localparam int COORD_BITS = 16;
  localparam int IN_COORD_W = 16;
  localparam int COUNT_W    = 8;
  localparam int TOL_W      = 8;
  localparam int TOLSQ_W    = 2 * TOL_W;
  localparam int IDX_W      = 2;

  localparam int DIFF_W  = COORD_BITS + 1;          // signed coordinate difference
  localparam int PROD_W  = 2 * DIFF_W;              // signed product of two differences
  localparam int SQ_W    = 2 * COORD_BITS;          // square of one difference
  localparam int DIST_W  = SQ_W + 1;                // sum of two squares
  localparam int CROSS_W = PROD_W + 1;              // difference of two products
  localparam int ACC_W   = 2 * COORD_BITS + 1;      // magnitude of the cross term
  localparam int HALF_W  = (ACC_W + 1) / 2;
  localparam int HI_W    = ACC_W - HALF_W;
  localparam int LHS_W   = 2 * ACC_W;
  localparam int RHS_W   = TOLSQ_W + DIST_W;
  localparam int CMP_W   = (LHS_W > RHS_W) ? LHS_W : RHS_W;

  // Pipeline depth from an accepted word to its result strobe.
  localparam int LAT = 8;

  localparam logic [COUNT_W-1:0] WAND_COUNT   = COUNT_W'(3);
  localparam logic [TOL_W-1:0]   TOL_RESET    = TOL_W'(24);
  localparam logic [TOLSQ_W-1:0] TOLSQ_RESET  = TOLSQ_W'(24 * 24);

  localparam logic [IDX_W-1:0] IDX_0 = 2'd0;
  localparam logic [IDX_W-1:0] IDX_1 = 2'd1;
  localparam logic [IDX_W-1:0] IDX_2 = 2'd2;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [DIST_W-1:0]     dist_t;
  typedef logic [IDX_W-1:0]      idx_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef point_t [2:0] trio_t;

  typedef struct packed {
    idx_t first;
    idx_t middle;
    idx_t last;
  } order_t;

  localparam order_t ORDER_KEEP = '{first: IDX_0, middle: IDX_1, last: IDX_2};

  typedef struct packed {
    logic [COUNT_W-1:0]    point_count;
    logic [IN_COORD_W-1:0] px0;
    logic [IN_COORD_W-1:0] py0;
    logic [IN_COORD_W-1:0] px1;
    logic [IN_COORD_W-1:0] py1;
    logic [IN_COORD_W-1:0] px2;
    logic [IN_COORD_W-1:0] py2;
  } in_word_t;

  typedef struct packed {
    logic found;
    logic cleared;
    idx_t first_index;
    idx_t middle_index;
    idx_t last_index;
  } out_word_t;

  function automatic point_t pick(input trio_t pts, input idx_t idx);
    point_t p;
    unique case (idx)
      IDX_0:   p = pts[0];
      IDX_1:   p = pts[1];
      IDX_2:   p = pts[2];
      default: p = pts[0];
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/core/tpld_pair_lane.sv
module tpld_pair_lane
  import tpld_pkg::*;
(
  input  logic   clk,
  input  point_t pa,
  input  point_t pb,
  output dist_t  dsq
);

  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic signed [PROD_W-1:0] sqx_full;
  logic signed [PROD_W-1:0] sqy_full;
  logic [SQ_W-1:0]          sqx;
  logic [SQ_W-1:0]          sqy;

  assign dx = $signed({1'b0, pa.x}) - $signed({1'b0, pb.x});
  assign dy = $signed({1'b0, pa.y}) - $signed({1'b0, pb.y});
  assign sqx_full = dx * dx;
  assign sqy_full = dy * dy;

  always_ff @(posedge clk) begin
    sqx <= sqx_full[SQ_W-1:0];
    sqy <= sqy_full[SQ_W-1:0];
    dsq <= {1'b0, sqx} + {1'b0, sqy};
  end

endmodule

FILE: rtl/core/tpld_order.sv
module tpld_order
  import tpld_pkg::*;
(
  input  logic   clk,
  input  dist_t  d01,
  input  dist_t  d02,
  input  dist_t  d12,
  output order_t ord
);

  order_t ord_next;
  idx_t   end_a;
  idx_t   end_b;
  idx_t   mid;
  logic   a_closer;

  always_comb begin
    // The longest pair gives the ends; the end nearer the middle comes first; any tie keeps input order.
    priority if (d01 > d02 && d01 > d12) begin
      end_a    = IDX_0;
      end_b    = IDX_1;
      mid      = IDX_2;
      a_closer = d02 < d12;
    end else if (d02 > d12) begin
      end_a    = IDX_0;
      end_b    = IDX_2;
      mid      = IDX_1;
      a_closer = d01 < d12;
    end else begin
      end_a    = IDX_1;
      end_b    = IDX_2;
      mid      = IDX_0;
      a_closer = d01 < d02;
    end

    if (d01 == d02 || d01 == d12 || d02 == d12) begin
      ord_next = ORDER_KEEP;
    end else begin
      ord_next.first  = a_closer ? end_a : end_b;
      ord_next.middle = mid;
      ord_next.last   = a_closer ? end_b : end_a;
    end
  end

  always_ff @(posedge clk) begin
    ord <= ord_next;
  end

endmodule

FILE: rtl/core/tpld_line_test.sv
module tpld_line_test
  import tpld_pkg::*;
(
  input  logic               clk,
  input  trio_t              pts,
  input  order_t             ord_in,
  input  logic [TOLSQ_W-1:0] tol_sq,
  output order_t             ord_out,
  output logic               found
);

  // Ends and middle differences.
  point_t                   p_first;
  point_t                   p_mid;
  point_t                   p_last;
  logic signed [DIFF_W-1:0] ex;
  logic signed [DIFF_W-1:0] ey;
  logic signed [DIFF_W-1:0] fx;
  logic signed [DIFF_W-1:0] fy;
  order_t                   ord4;

  // Products.
  logic signed [PROD_W-1:0] pa_c;
  logic signed [PROD_W-1:0] pb_c;
  logic signed [PROD_W-1:0] sq_ex_c;
  logic signed [PROD_W-1:0] sq_ey_c;
  logic signed [PROD_W-1:0] prod_a;
  logic signed [PROD_W-1:0] prod_b;
  logic [SQ_W-1:0]          sq_ex;
  logic [SQ_W-1:0]          sq_ey;
  order_t                   ord5;

  // Cross term magnitude and squared length.
  logic signed [CROSS_W-1:0] cr;
  logic signed [CROSS_W-1:0] cr_abs;
  logic [ACC_W-1:0]          ac;
  dist_t                     len2;
  order_t                    ord6;

  // Partial products of the cross term square, and the bound.
  logic [HI_W-1:0]          ac_hi;
  logic [HALF_W-1:0]        ac_lo;
  logic [2*HI_W-1:0]        pp_hh;
  logic [HI_W+HALF_W-1:0]   pp_hl;
  logic [2*HALF_W-1:0]      pp_ll;
  logic [RHS_W-1:0]         rhs;
  logic                     len_nz;
  order_t                   ord7;

  logic [CMP_W-1:0] lhs;

  assign p_first = pick(pts, ord_in.first);
  assign p_mid   = pick(pts, ord_in.middle);
  assign p_last  = pick(pts, ord_in.last);

  always_ff @(posedge clk) begin
    ex   <= $signed({1'b0, p_last.x}) - $signed({1'b0, p_first.x});
    ey   <= $signed({1'b0, p_last.y}) - $signed({1'b0, p_first.y});
    fx   <= $signed({1'b0, p_first.x}) - $signed({1'b0, p_mid.x});
    fy   <= $signed({1'b0, p_first.y}) - $signed({1'b0, p_mid.y});
    ord4 <= ord_in;
  end

  assign pa_c    = ex * fy;
  assign pb_c    = fx * ey;
  assign sq_ex_c = ex * ex;
  assign sq_ey_c = ey * ey;

  always_ff @(posedge clk) begin
    prod_a <= pa_c;
    prod_b <= pb_c;
    sq_ex  <= sq_ex_c[SQ_W-1:0];
    sq_ey  <= sq_ey_c[SQ_W-1:0];
    ord5   <= ord4;
  end

  assign cr     = $signed({prod_a[PROD_W-1], prod_a}) - $signed({prod_b[PROD_W-1], prod_b});
  assign cr_abs = cr[CROSS_W-1] ? -cr : cr;

  always_ff @(posedge clk) begin
    ac   <= cr_abs[ACC_W-1:0];
    len2 <= {1'b0, sq_ex} + {1'b0, sq_ey};
    ord6 <= ord5;
  end

  // The cross term magnitude is split in halves to keep each multiplier of its square narrow.
  assign ac_lo = ac[HALF_W-1:0];
  assign ac_hi = ac[ACC_W-1:HALF_W];

  always_ff @(posedge clk) begin
    pp_hh  <= ac_hi * ac_hi;
    pp_hl  <= ac_hi * ac_lo;
    pp_ll  <= ac_lo * ac_lo;
    rhs    <= tol_sq * len2;
    len_nz <= |len2;
    ord7   <= ord6;
  end

  assign lhs = (CMP_W'(pp_hh) << (2 * HALF_W))
             + (CMP_W'(pp_hl) << (HALF_W + 1))
             + CMP_W'(pp_ll);

  always_ff @(posedge clk) begin
    found   <= len_nz && (lhs < CMP_W'(rhs));
    ord_out <= ord7;
  end

endmodule

FILE: rtl/core/three_point_line_detector_top.sv
// Three-point line detector.
//
// A word on points is taken at every rising edge with start high and busy
// low. busy is never raised, so a new word may be issued every cycle: the
// block sustains one word per clock cycle.
// Each word gives exactly one result word, shown on result for one cycle
// with done high once the word has passed all pipeline registers. Results
// come out in input order. The receiver cannot hold them off and the
// pipeline has no stall path.
// The word passes the three pairwise distance lanes, which register the
// squares and then their sum, the ordering register, and the line test,
// whose squared cross term is built from three half-width partial products.
// line_tolerance is written through cfg_we and cfg_wdata; its square is kept
// in a register. Write it only while no word is in flight.
// A synchronous reset drops all words in flight and sets the tolerance to
// 24 sixteenths of a pixel.
module three_point_line_detector_top
  import tpld_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  in_word_t         points,
  input  logic             cfg_we,
  input  logic [TOL_W-1:0] cfg_wdata,
  output logic             done,
  output out_word_t        result
);

  logic               accept;
  logic [TOLSQ_W-1:0] tol_sq;
  trio_t              pts0;
  trio_t              pts1;
  trio_t              pts2;
  trio_t              pts3;
  dist_t              d01;
  dist_t              d02;
  dist_t              d12;
  order_t             ord3;
  order_t             ord8;
  logic               line_ok;
  logic [LAT-1:0]     vld_sr;
  logic [LAT-1:0]     three_sr;
  logic               three8;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol_sq <= TOLSQ_RESET;
    end else if (cfg_we) begin
      tol_sq <= cfg_wdata * cfg_wdata;
    end
  end

  assign pts0[0] = '{x: points.px0[COORD_BITS-1:0], y: points.py0[COORD_BITS-1:0]};
  assign pts0[1] = '{x: points.px1[COORD_BITS-1:0], y: points.py1[COORD_BITS-1:0]};
  assign pts0[2] = '{x: points.px2[COORD_BITS-1:0], y: points.py2[COORD_BITS-1:0]};

  tpld_pair_lane u_lane01 (.clk(clk), .pa(pts0[0]), .pb(pts0[1]), .dsq(d01));
  tpld_pair_lane u_lane02 (.clk(clk), .pa(pts0[0]), .pb(pts0[2]), .dsq(d02));
  tpld_pair_lane u_lane12 (.clk(clk), .pa(pts0[1]), .pb(pts0[2]), .dsq(d12));

  tpld_order u_order (.clk(clk), .d01(d01), .d02(d02), .d12(d12), .ord(ord3));

  // Coordinates follow the lanes and the ordering stage.
  always_ff @(posedge clk) begin
    pts1 <= pts0;
    pts2 <= pts1;
    pts3 <= pts2;
  end

  tpld_line_test u_line (
    .clk    (clk),
    .pts    (pts3),
    .ord_in (ord3),
    .tol_sq (tol_sq),
    .ord_out(ord8),
    .found  (line_ok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_sr <= '0;
    end else begin
      vld_sr <= {vld_sr[LAT-2:0], accept};
    end
    three_sr <= {three_sr[LAT-2:0], points.point_count == WAND_COUNT};
  end

  assign three8 = three_sr[LAT-1];
  assign done   = vld_sr[LAT-1];

  always_comb begin
    result.found   = three8 && line_ok;
    result.cleared = three8 && !line_ok;
    if (three8 && line_ok) begin
      result.first_index  = ord8.first;
      result.middle_index = ord8.middle;
      result.last_index   = ord8.last;
    end else begin
      result.first_index  = ORDER_KEEP.first;
      result.middle_index = ORDER_KEEP.middle;
      result.last_index   = ORDER_KEEP.last;
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LAT done)
    else $error("accepted word did not produce a result after LAT cycles");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result strobe without a matching accepted word");

  a_flags_exclusive: assert property (@(posedge clk)
    done |-> !(result.found && result.cleared))
    else $error("found and cleared both set");

  a_found_distinct: assert property (@(posedge clk)
    done && result.found |-> result.first_index != result.middle_index &&
      result.first_index != result.last_index &&
      result.middle_index != result.last_index)
    else $error("found result with repeated point index");

  a_reject_order: assert property (@(posedge clk)
    done && !result.found |-> result.first_index == IDX_0 &&
      result.middle_index == IDX_1 && result.last_index == IDX_2)
    else $error("rejected result does not keep the original order");

endmodule

FILE: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tpld_pkg::*;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  in_word_t         points = '0;
  logic             cfg_we = 1'b0;
  logic [TOL_W-1:0] cfg_wdata = '0;
  logic             done;
  out_word_t        result;

  in_word_t  pending_points[$];
  out_word_t pending_verdicts[$];
  logic [TOL_W-1:0] tol_now = TOL_RESET;
  int mismatch_count = 0;
  int burst_left = 1;
  int gap_left = 0;

  three_point_line_detector_top dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .points   (points),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .done     (done),
    .result   (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void add_frame(in_word_t w);
    pending_points.insert(pending_points.size(), w);
  endfunction

  // Expected verdict for one word of points under the given tolerance.
  function automatic out_word_t wand_verdict(in_word_t w, logic [TOL_W-1:0] tol);
    longint x[3];
    longint y[3];
    longint pair_sq[3][3];
    longint ex, ey, cr, len2, tsq;
    logic [63:0] mag;
    logic [127:0] cr_sq, bound;
    idx_t first, mid, last, a, b;
    out_word_t r;
    r = '0;
    r.first_index = IDX_0;
    r.middle_index = IDX_1;
    r.last_index = IDX_2;
    if (w.point_count != WAND_COUNT) return r;
    x[0] = longint'(coord_t'(w.px0));
    y[0] = longint'(coord_t'(w.py0));
    x[1] = longint'(coord_t'(w.px1));
    y[1] = longint'(coord_t'(w.py1));
    x[2] = longint'(coord_t'(w.px2));
    y[2] = longint'(coord_t'(w.py2));
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pair_sq[i][j] = (x[i] - x[j]) * (x[i] - x[j]) + (y[i] - y[j]) * (y[i] - y[j]);
      end
    end
    first = IDX_0;
    mid = IDX_1;
    last = IDX_2;
    // Any tie among the pair distances keeps the points in input order.
    if (pair_sq[0][1] != pair_sq[0][2] && pair_sq[0][1] != pair_sq[1][2] &&
        pair_sq[0][2] != pair_sq[1][2]) begin
      if (pair_sq[0][1] > pair_sq[0][2] && pair_sq[0][1] > pair_sq[1][2]) begin
        a = IDX_0; b = IDX_1; mid = IDX_2;
      end else if (pair_sq[0][2] > pair_sq[1][2]) begin
        a = IDX_0; b = IDX_2; mid = IDX_1;
      end else begin
        a = IDX_1; b = IDX_2; mid = IDX_0;
      end
      if (pair_sq[a][mid] < pair_sq[b][mid]) begin
        first = a; last = b;
      end else begin
        first = b; last = a;
      end
    end
    ex = x[last] - x[first];
    ey = y[last] - y[first];
    cr = ex * (y[first] - y[mid]) - (x[first] - x[mid]) * ey;
    mag = (cr < 0) ? -cr : cr;
    len2 = ex * ex + ey * ey;
    tsq = longint'(tol) * longint'(tol);
    cr_sq = {64'd0, mag} * {64'd0, mag};
    bound = {64'd0, tsq} * {64'd0, len2};
    if (len2 != 0 && cr_sq < bound) begin
      r.found = 1'b1;
      r.first_index = first;
      r.middle_index = mid;
      r.last_index = last;
    end else begin
      r.cleared = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [IN_COORD_W-1:0] clamp_coord(int v);
    if (v < 0) return '0;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  function automatic in_word_t frame(int cnt, int x0, int y0, int x1, int y1,
                                     int x2, int y2);
    in_word_t w;
    w.point_count = cnt[7:0];
    w.px0 = clamp_coord(x0);
    w.py0 = clamp_coord(y0);
    w.px1 = clamp_coord(x1);
    w.py1 = clamp_coord(y1);
    w.px2 = clamp_coord(x2);
    w.py2 = clamp_coord(y2);
    return w;
  endfunction

  function automatic int spread(int m);
    return int'($urandom_range(0, 2 * m)) - m;
  endfunction

  // Mostly near-straight wands in random order, with ties, full-range noise
  // and counts other than three mixed in.
  function automatic in_word_t random_frame();
    int pm[6][3] = '{'{0, 1, 2}, '{0, 2, 1}, '{1, 0, 2}, '{1, 2, 0}, '{2, 0, 1}, '{2, 1, 0}};
    int px[3];
    int py[3];
    int kind, cnt, perm, span, bx, by, sx, sy, t, k, m;
    kind = $urandom_range(0, 99);
    cnt = 3;
    if (kind < 20) begin
      if (kind < 8) begin
        cnt = $urandom_range(0, 255);
        if (cnt == 3) cnt = 4;
      end
      for (int i = 0; i < 3; i++) begin
        px[i] = $urandom_range(0, 65535);
        py[i] = $urandom_range(0, 65535);
      end
    end else if (kind < 32) begin
      // Middle on the perpendicular bisector, so two distances tie.
      bx = $urandom_range(1000, 64535);
      by = $urandom_range(1000, 64535);
      sx = spread(500);
      sy = spread(500);
      t = $urandom_range(0, 2);
      px[0] = bx - sx; py[0] = by - sy;
      px[1] = bx + t * sy; py[1] = by - t * sx;
      px[2] = bx + sx; py[2] = by + sy;
    end else begin
      case ($urandom_range(0, 3))
        0: span = 16;
        1: span = 400;
        2: span = 8000;
        default: span = 65535;
      endcase
      px[0] = $urandom_range(0, 65535);
      py[0] = $urandom_range(0, 65535);
      if (kind < 35) begin
        px[2] = px[0]; py[2] = py[0];
      end else begin
        px[2] = clamp_coord(px[0] + spread(span));
        py[2] = clamp_coord(py[0] + spread(span));
      end
      case ($urandom_range(0, 3))
        0: m = 0;
        1: m = 8;
        2: m = $urandom_range(0, 400);
        default: m = 1000;
      endcase
      k = $urandom_range(1, 15);
      px[1] = px[0] + (px[2] - px[0]) * k / 16 + spread(m);
      py[1] = py[0] + (py[2] - py[0]) * k / 16 + spread(m);
    end
    perm = $urandom_range(0, 5);
    return frame(cnt, px[pm[perm][0]], py[pm[perm][0]], px[pm[perm][1]], py[pm[perm][1]],
                 px[pm[perm][2]], py[pm[perm][2]]);
  endfunction

  // Sender: words go out in bursts with random gaps between them.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        pending_verdicts.insert(pending_verdicts.size(),
                                wand_verdict(pending_points[0], tol_now));
        void'(pending_points.pop_front());
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_points.size() > 0) begin
          start <= 1'b1;
          points <= pending_points[0];
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && done) begin
      if (pending_verdicts.size() == 0) begin
        mismatch_count++;
        $display("%0t: result word with none expected, got %p", $time, result);
      end else begin
        want = pending_verdicts.pop_front();
        check_field("found", want.found, result.found);
        check_field("cleared", want.cleared, result.cleared);
        check_field("first_index", want.first_index, result.first_index);
        check_field("middle_index", want.middle_index, result.middle_index);
        check_field("last_index", want.last_index, result.last_index);
      end
    end
  end

  task automatic wait_drained();
    while (pending_points.size() != 0 || pending_verdicts.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic [TOL_W-1:0] tol_plan[6];
    tol_plan = '{8'd0, 8'd255, 8'd1, 8'd0, 8'd0, 8'd40};
    tol_plan[3] = TOL_W'($urandom_range(2, 254));
    tol_plan[4] = TOL_W'($urandom_range(2, 254));
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    add_frame(frame(0, 0, 0, 0, 0, 0, 0));
    add_frame(frame(2, 100, 100, 200, 200, 300, 300));
    add_frame(frame(4, 100, 100, 200, 200, 300, 300));
    add_frame(frame(255, 65535, 65535, 65535, 65535, 65535, 65535));
    add_frame(frame(8'h83, 0, 0, 500, 0, 1000, 0));
    add_frame(frame(3, 0, 0, 0, 0, 0, 0));
    add_frame(frame(3, 65535, 65535, 65535, 65535, 65535, 65535));
    add_frame(frame(3, 0, 0, 65535, 65535, 32767, 32767));
    add_frame(frame(3, 65535, 0, 0, 65535, 32768, 32767));
    // Middle exactly at the tolerance fails; one step closer passes.
    add_frame(frame(3, 0, 0, 300, 24, 1000, 0));
    add_frame(frame(3, 1000, 0, 300, 23, 0, 0));
    add_frame(frame(3, 600, 23, 0, 0, 1000, 0));
    add_frame(frame(3, 0, 0, 100, 0, 200, 0));
    add_frame(frame(3, 0, 0, 200, 0, 100, 0));
    add_frame(frame(3, 0, 0, 100, 50, 200, 0));
    add_frame(frame(3, 5, 5, 5, 5, 100, 100));
    add_frame(frame(3, 65535, 65535, 0, 0, 65535, 0));
    add_frame(frame(3, 10, 10, 10, 500, 11, 250));
    add_frame(frame(3, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'hFFFF, 0));
    add_frame(frame(3, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 0, 16'hFFFF));
    for (int i = 0; i < 60; i++) add_frame(random_frame());
    wait_drained();
    foreach (tol_plan[p]) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_wdata <= tol_plan[p];
      @(posedge clk);
      cfg_we <= 1'b0;
      tol_now = tol_plan[p];
      @(negedge clk);
      for (int i = 0; i < 300; i++) add_frame(random_frame());
      wait_drained();
    end
    repeat (LAT + 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
